@@ hw/rtl/cftq_pkg.sv @@
// Package for the checksummed frame transmit queue: sizes, frame constants,
// command codes and the slot addressing helpers. No dependencies.
`timescale 1ns / 1ps
package cftq_pkg;

  localparam int FRAME_SLOTS  = 8;
  localparam int MAX_PAYLOAD  = 32;
  localparam int SLOT_BYTES   = MAX_PAYLOAD + 7;
  localparam int STORE_DEPTH  = FRAME_SLOTS * SLOT_BYTES;

  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam int POS_W  = $clog2(SLOT_BYTES);
  localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  localparam logic [7:0] SYNC_A       = 8'hFE;
  localparam logic [7:0] SYNC_B       = 8'hDA;
  localparam logic [7:0] HEADER_EXTRA = 8'd7;
  localparam logic [2:0] SEND_PHASE   = 3'd5;
  localparam int         HDR_BYTES    = 6;

  typedef enum logic [1:0] {
    CMD_OPEN    = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_TICK    = 2'd2
  } cftq_cmd_e;

  function automatic logic [ADDR_W-1:0] byte_addr(logic [SLOT_W-1:0] slot,
                                                  logic [POS_W-1:0]  pos);
    return ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos);
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] slot);
    return (slot == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : slot + SLOT_W'(1);
  endfunction

endpackage

@@ hw/rtl/checksummed_frame_tx_queue.sv @@
// Checksummed frame transmit queue: builds frames into a ring of slots held in
// one synchronous byte memory and sends the oldest completed frame on every
// sixth timer tick. Depends on cftq_pkg.
`timescale 1ns / 1ps
// Usage:
//   Slave stream: tuser carries the command (open frame, payload byte, tick),
//   tdata the header fields and payload byte. Master stream: tdata is the
//   sent byte, tlast marks the final byte of a frame or a drop report, tuser
//   flags a drop report (an open refused because the ring is full).
// Work per input transfer:
//   open frame  : one memory write per header byte; a zero-length frame adds
//                 the checksum write.
//   payload byte: one memory write; the final byte adds the checksum write.
//   tick        : on the sending tick the input side stays closed while the
//                 frame (len+7 bytes) goes out, each byte as a memory read and
//                 then a load of the output register.
//   drop report : waits for a free output register, then loads the report.
// Reset clears the ring pointers, tick phase and the output register. The
// frame memory is not cleared: only completed frames are ever read.
// A stalled sink holds the output register; the send sequence waits on it
// and issues no further memory read until the register drains.
// Sends read only the tail slot and builds write only the head slot, which
// differ whenever a send runs, and no write happens during a send, so the
// memory needs no forwarding.
module checksummed_frame_tx_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] src_id, [15:8] dst_id, [23:16] msg_code, [29:24] payload_len,
  // [37:30] payload_byte, [39:38] zero
  input  logic [cftq_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] tx_byte
  output logic [cftq_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // last_byte
  output logic                          m_axis_tlast_o,
  // [0] dropped
  output logic                          m_axis_tuser_o
);
  import cftq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_CSUM,
    ST_DROP,
    ST_SEND
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [2:0]        phase_q, phase_d;
  logic [LEN_W-1:0]  fill_q, fill_d, blen_q, blen_d;
  logic [7:0]        sum_q, sum_d;
  logic              build_q, build_d;
  logic [2:0]        hidx_q, hidx_d;
  logic [7:0]        lbyte_q, lbyte_d, src_q, src_d, dst_q, dst_d, code_q, code_d;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              rdp_q, rdp_d;
  logic              ov_q, ov_d, olast_q, olast_d, odrop_q, odrop_d;
  logic [7:0]        obyte_q, obyte_d;

  // frame memory
  logic [7:0]        mem [STORE_DEPTH];
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata_q;

  // input fields
  logic [7:0]       in_src, in_dst, in_code, in_pay;
  logic [5:0]       in_len;
  logic [LEN_W-1:0] len_sat;
  logic [7:0]       len_byte, open_sum;
  logic             in_acc, ring_full, out_free;
  logic [CNT_W-1:0] tot_now;
  logic             send_last;

  assign in_src  = s_axis_tdata_i[7:0];
  assign in_dst  = s_axis_tdata_i[15:8];
  assign in_code = s_axis_tdata_i[23:16];
  assign in_len  = s_axis_tdata_i[29:24];
  assign in_pay  = s_axis_tdata_i[37:30];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign ring_full       = (next_slot(head_q) == tail_q);
  // output register is empty now or drains at this edge
  assign out_free        = !ov_q || m_axis_tready_i;

  assign len_sat  = (in_len > 6'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(in_len);
  assign len_byte = 8'(len_sat) + HEADER_EXTRA;
  assign open_sum = SYNC_A + SYNC_B + len_byte + in_src + in_dst + in_code;

  // frame length comes from the length byte (byte 2) as it is read back
  assign tot_now   = (idx_q == POS_W'(2)) ?
                     ((rdata_q > 8'(SLOT_BYTES)) ? CNT_W'(SLOT_BYTES) : CNT_W'(rdata_q)) :
                     total_q;
  assign send_last = ((CNT_W'(idx_q) + CNT_W'(1)) == tot_now);

  assign raddr = byte_addr(tail_q, idx_q);
  assign rd_en = (state_q == ST_SEND) && !rdp_q && out_free;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    phase_d = phase_q;
    fill_d  = fill_q;
    blen_d  = blen_q;
    sum_d   = sum_q;
    build_d = build_q;
    hidx_d  = hidx_q;
    lbyte_d = lbyte_q;
    src_d   = src_q;
    dst_d   = dst_q;
    code_d  = code_q;
    idx_d   = idx_q;
    total_d = total_q;
    rdp_d   = rdp_q;
    ov_d    = ov_q && !m_axis_tready_i;
    olast_d = olast_q;
    odrop_d = odrop_q;
    obyte_d = obyte_q;
    mem_we  = 1'b0;
    waddr   = byte_addr(head_q, '0);
    wdata   = SYNC_A;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cftq_cmd_e'(s_axis_tuser_i))
            CMD_OPEN: begin
              if (ring_full) begin
                build_d = 1'b0;
                state_d = ST_DROP;
              end else begin
                mem_we  = 1'b1;
                waddr   = byte_addr(head_q, '0);
                wdata   = SYNC_A;
                lbyte_d = len_byte;
                src_d   = in_src;
                dst_d   = in_dst;
                code_d  = in_code;
                sum_d   = open_sum;
                blen_d  = len_sat;
                fill_d  = '0;
                build_d = 1'b1;
                hidx_d  = 3'd1;
                state_d = ST_HDR;
              end
            end
            CMD_PAYLOAD: begin
              if (build_q) begin
                mem_we = 1'b1;
                waddr  = byte_addr(head_q, POS_W'(HDR_BYTES) + POS_W'(fill_q));
                wdata  = in_pay;
                sum_d  = sum_q + in_pay;
                fill_d = fill_q + LEN_W'(1);
                if ((fill_q + LEN_W'(1)) >= blen_q) begin
                  state_d = ST_CSUM;
                end
              end
            end
            CMD_TICK: begin
              if (phase_q == SEND_PHASE) begin
                phase_d = '0;
                if (tail_q != head_q) begin
                  idx_d   = '0;
                  total_d = CNT_W'(SLOT_BYTES);
                  rdp_d   = 1'b0;
                  state_d = ST_SEND;
                end
              end else begin
                phase_d = phase_q + 3'd1;
              end
            end
            default: ;  // unused command, no effect
          endcase
        end
      end

      ST_HDR: begin
        mem_we = 1'b1;
        waddr  = byte_addr(head_q, POS_W'(hidx_q));
        case (hidx_q)
          3'd1:    wdata = SYNC_B;
          3'd2:    wdata = lbyte_q;
          3'd3:    wdata = src_q;
          3'd4:    wdata = dst_q;
          default: wdata = code_q;
        endcase
        hidx_d = hidx_q + 3'd1;
        if (hidx_q == 3'(HDR_BYTES - 1)) begin
          state_d = (blen_q == '0) ? ST_CSUM : ST_IDLE;
        end
      end

      ST_CSUM: begin
        mem_we  = 1'b1;
        waddr   = byte_addr(head_q, POS_W'(HDR_BYTES) + POS_W'(blen_q));
        wdata   = sum_q;
        head_d  = next_slot(head_q);
        build_d = 1'b0;
        state_d = ST_IDLE;
      end

      ST_DROP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          obyte_d = '0;
          olast_d = 1'b1;
          odrop_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_SEND: begin
        if (rd_en) begin
          rdp_d = 1'b1;
        end
        if (rdp_q) begin
          // read data lands now; output register was freed when it was issued
          ov_d    = 1'b1;
          obyte_d = rdata_q;
          olast_d = send_last;
          odrop_d = 1'b0;
          total_d = tot_now;
          idx_d   = idx_q + POS_W'(1);
          rdp_d   = 1'b0;
          if (send_last) begin
            tail_d  = next_slot(tail_q);
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      phase_q <= '0;
      fill_q  <= '0;
      blen_q  <= '0;
      sum_q   <= '0;
      build_q <= 1'b0;
      hidx_q  <= '0;
      lbyte_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      code_q  <= '0;
      idx_q   <= '0;
      total_q <= CNT_W'(SLOT_BYTES);
      rdp_q   <= 1'b0;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
      odrop_q <= 1'b0;
      obyte_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      phase_q <= phase_d;
      fill_q  <= fill_d;
      blen_q  <= blen_d;
      sum_q   <= sum_d;
      build_q <= build_d;
      hidx_q  <= hidx_d;
      lbyte_q <= lbyte_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      code_q  <= code_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      rdp_q   <= rdp_d;
      ov_q    <= ov_d;
      olast_q <= olast_d;
      odrop_q <= odrop_d;
      obyte_q <= obyte_d;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = obyte_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = odrop_q;

endmodule

@@ hw/rtl/cftq_checker.sv @@
// Port-level checker for the checksummed frame transmit queue, bound to the
// top level. Depends on cftq_pkg.
`timescale 1ns / 1ps
module cftq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [1:0]                    s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [cftq_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  input logic                          m_axis_tlast_o,
  input logic                          m_axis_tuser_o
);
  import cftq_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("stalled output changed");

  // a drop report is a single zero byte marked last
  a_drop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("malformed drop report");

  // the input is not ready in the cycle after an accepted open-frame transfer
  a_open_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o &&
      (s_axis_tuser_i == 2'(CMD_OPEN)) |=> !s_axis_tready_o)
    else $error("input ready right after open frame");

  // nothing is offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind checksummed_frame_tx_queue cftq_checker u_cftq_checker (.*);
